/* design/ivd_pkg.sv */
// ----------------------------------------------------------------------------
// ivd_pkg
// Widths and codes shared by the IR voltage to distance interpolation core.
// ----------------------------------------------------------------------------
`default_nettype none

package ivd_pkg;

    // payload widths
    localparam int CMD_W    = 2;
    localparam int SENSOR_W = 3;
    localparam int ENTRY_W  = 6;
    localparam int LEVEL_W  = 13;
    localparam int DIST_W   = 8;
    localparam int USED_W   = 7;
    localparam int STATUS_W = 2;

    // interpolation arithmetic: numerator is span * distance at most
    localparam int NUM_W    = LEVEL_W + DIST_W;
    localparam int QUOT_W   = DIST_W;
    localparam int DIV_CNT_W = $clog2(QUOT_W);

    typedef logic [CMD_W-1:0]    cmd_t;
    typedef logic [SENSOR_W-1:0] sensor_t;
    typedef logic [ENTRY_W-1:0]  entry_t;
    typedef logic [LEVEL_W-1:0]  level_t;
    typedef logic [DIST_W-1:0]   dist_t;
    typedef logic [USED_W-1:0]   used_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [NUM_W-1:0]    num_t;

    // command codes
    localparam cmd_t CMD_CONVERT = 2'd0;
    localparam cmd_t CMD_WR_VOLT = 2'd1;
    localparam cmd_t CMD_WR_DIST = 2'd2;

    // result status codes
    localparam status_t ST_INTERP = 2'd0;
    localparam status_t ST_NEAR   = 2'd1;
    localparam status_t ST_FAR    = 2'd2;
    localparam status_t ST_ACK    = 2'd3;

endpackage

`default_nettype wire

/* design/ir_voltage_to_distance_interp_core.sv */
// ----------------------------------------------------------------------------
// ir_voltage_to_distance_interp_core
// Converts an IR sensor voltage (mV) into a distance (0.2 cm units) by a
// linear search of a per-sensor descending voltage table and interpolation
// between two entries of a shared distance table.
//
// channel | direction | handshake            | payload
// --------+-----------+----------------------+------------------------------
// input   | in        | in_valid / in_ready  | command sensor entry level_mv
//         |           |                      | dist_value used_entries
// output  | out       | out_valid / out_ready| distance status
//
// A write goes straight to the result state with status ACK. A convert
// visits m voltage entries (1..TABLE_DEPTH), one entry a cycle through the
// voltage table read port; when it saturates it then fetches one distance
// entry, and when it interpolates it makes two passes of the shared
// multiplier and an 8-step restoring divider. in_ready is high only while
// the sequencer is idle; a finished result waits in the output register.
// Reset clears control state only; table contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module ir_voltage_to_distance_interp_core #(
    parameter int SENSOR_COUNT = 5,
    parameter int TABLE_DEPTH  = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,

    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire ivd_pkg::cmd_t     command,
    input  wire ivd_pkg::sensor_t  sensor,
    input  wire ivd_pkg::entry_t   entry,
    input  wire ivd_pkg::level_t   level_mv,
    input  wire ivd_pkg::dist_t    dist_value,
    input  wire ivd_pkg::used_t    used_entries,

    output logic                   out_valid,
    input  wire logic              out_ready,
    output ivd_pkg::dist_t         distance,
    output ivd_pkg::status_t       status
);

    import ivd_pkg::*;

    localparam int K_W    = $clog2(TABLE_DEPTH);
    localparam int SIDX_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
    localparam int VA_W   = (SENSOR_COUNT * TABLE_DEPTH > 1)
                          ? $clog2(SENSOR_COUNT * TABLE_DEPTH) : 1;
    localparam int VDEPTH = SENSOR_COUNT * TABLE_DEPTH;

    localparam logic [K_W-1:0]       K_LAST   = K_W'(TABLE_DEPTH - 1);
    localparam logic [SIDX_W-1:0]    S_LAST   = SIDX_W'(SENSOR_COUNT - 1);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(QUOT_W - 1);

    // sequencer states
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SEARCH  = 4'd1;
    localparam logic [3:0] S_WAIT    = 4'd2;
    localparam logic [3:0] S_MUL1    = 4'd3;
    localparam logic [3:0] S_MUL2    = 4'd4;
    localparam logic [3:0] S_DIV     = 4'd5;
    localparam logic [3:0] S_FETCH_W = 4'd6;
    localparam logic [3:0] S_FETCH   = 4'd7;
    localparam logic [3:0] S_DONE    = 4'd8;

    logic [3:0]           state_reg, state_next;

    // tables
    level_t               volt_mem [VDEPTH];
    dist_t                dist_mem [TABLE_DEPTH];
    level_t               vrd_reg;
    dist_t                drd_reg;

    // sequencer datapath
    logic [VA_W-1:0]      base_reg;
    logic [K_W-1:0]       k_reg;
    logic [K_W-1:0]       last_reg;
    logic [K_W-1:0]       dist_idx_reg;
    level_t               v_reg;
    level_t               hi_reg;
    level_t               lo_reg;
    level_t               wa_reg;
    level_t               wb_reg;
    num_t                 rem_reg;
    num_t                 dvs_reg;
    dist_t                q_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    dist_t                res_dist_reg;
    status_t              res_st_reg;

    // output register
    logic                 out_valid_reg;
    dist_t                distance_reg;
    status_t              status_reg;

    logic                 in_xfer;
    logic                 out_load;
    logic [SIDX_W-1:0]    sidx_in;
    logic [VA_W-1:0]      base_in;
    logic [K_W-1:0]       last_in;
    logic [K_W-1:0]       k_step;
    logic [VA_W-1:0]      vrd_addr;
    logic                 volt_we;
    logic                 dist_we;
    logic [VA_W-1:0]      volt_waddr;
    logic [K_W-1:0]       entry_idx;
    logic                 hit_near;
    logic                 hit_found;
    logic                 hit_far;
    level_t               mul_a;
    num_t                 prod;
    num_t                 rem_sub;
    logic                 div_ge;
    dist_t                q_step;

    assign in_ready = (state_reg == S_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    // input decode: saturate sensor and entry count
    assign sidx_in = (32'(sensor) >= 32'(SENSOR_COUNT)) ? S_LAST : SIDX_W'(sensor);
    assign base_in = VA_W'(32'(sidx_in) * 32'(TABLE_DEPTH));

    always_comb
    begin
        if (used_entries == '0)
            last_in = '0;
        else if (32'(used_entries) > 32'(TABLE_DEPTH))
            last_in = K_LAST;
        else
            last_in = K_W'(32'(used_entries) - 32'd1);
    end

    assign entry_idx  = K_W'(entry);
    assign volt_waddr = VA_W'(32'(sensor) * 32'(TABLE_DEPTH) + 32'(entry));
    assign volt_we    = in_xfer && (command == CMD_WR_VOLT)
                     && (32'(sensor) < 32'(SENSOR_COUNT))
                     && (32'(entry) < 32'(TABLE_DEPTH));
    assign dist_we    = in_xfer && (command == CMD_WR_DIST)
                     && (32'(entry) < 32'(TABLE_DEPTH));

    // search address runs one entry ahead of the compare
    assign k_step   = (k_reg == K_LAST) ? k_reg : k_reg + 1'b1;
    assign vrd_addr = (state_reg == S_IDLE) ? base_in : base_reg + VA_W'(k_step);

    // voltage table, registered read
    always_ff @(posedge clk)
    begin
        if (volt_we)
            volt_mem[volt_waddr] <= level_mv;
        vrd_reg <= volt_mem[vrd_addr];
    end

    // distance table, registered read
    always_ff @(posedge clk)
    begin
        if (dist_we)
            dist_mem[entry_idx] <= dist_value;
        drd_reg <= dist_mem[dist_idx_reg];
    end

    // search decisions on the entry now read
    assign hit_near  = (k_reg == '0) && (v_reg >= vrd_reg);
    assign hit_found = (k_reg != '0) && (vrd_reg < v_reg);
    assign hit_far   = !hit_near && !hit_found && (k_reg == last_reg);

    // shared multiplier and divider step
    assign mul_a   = (state_reg == S_MUL1) ? wa_reg : wb_reg;
    assign prod    = NUM_W'(mul_a) * NUM_W'(drd_reg);
    assign div_ge  = (rem_reg >= dvs_reg);
    assign rem_sub = rem_reg - dvs_reg;
    assign q_step  = {q_reg[QUOT_W-2:0], div_ge};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                    state_next = (command == CMD_CONVERT) ? S_SEARCH : S_DONE;
            end
            S_SEARCH:
            begin
                if (hit_found)
                    state_next = S_WAIT;
                else if (hit_near || hit_far)
                    state_next = S_FETCH_W;
            end
            S_WAIT:    state_next = S_MUL1;
            S_MUL1:    state_next = S_MUL2;
            S_MUL2:    state_next = S_DIV;
            S_DIV:
            begin
                if (div_cnt_reg == DIV_LAST)
                    state_next = S_DONE;
            end
            S_FETCH_W: state_next = S_FETCH;
            S_FETCH:   state_next = S_DONE;
            S_DONE:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // sequencer datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                base_reg     <= base_in;
                last_reg     <= last_in;
                v_reg        <= level_mv;
                k_reg        <= '0;
                res_dist_reg <= '0;
                res_st_reg   <= ST_ACK;
            end
            S_SEARCH:
            begin
                if (hit_near)
                begin
                    dist_idx_reg <= '0;
                    res_st_reg   <= ST_NEAR;
                end
                else if (hit_found)
                begin
                    dist_idx_reg <= k_reg;
                    lo_reg       <= vrd_reg;
                    res_st_reg   <= ST_INTERP;
                end
                else if (hit_far)
                begin
                    dist_idx_reg <= k_reg;
                    res_st_reg   <= ST_FAR;
                end
                else
                begin
                    hi_reg <= vrd_reg;
                    k_reg  <= k_step;
                end
            end
            S_WAIT:
            begin
                dist_idx_reg <= k_reg - 1'b1;
                wa_reg       <= hi_reg - v_reg;
                wb_reg       <= v_reg - lo_reg;
            end
            S_MUL1:
            begin
                rem_reg <= prod;
            end
            S_MUL2:
            begin
                rem_reg     <= rem_reg + prod;
                dvs_reg     <= NUM_W'({wa_reg + wb_reg, {(QUOT_W-1){1'b0}}});
                q_reg       <= '0;
                div_cnt_reg <= '0;
            end
            S_DIV:
            begin
                if (div_ge)
                    rem_reg <= rem_sub;
                dvs_reg     <= dvs_reg >> 1;
                q_reg       <= q_step;
                div_cnt_reg <= div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_LAST)
                    res_dist_reg <= q_step;
            end
            S_FETCH:
            begin
                res_dist_reg <= drd_reg;
            end
            default:
            begin
            end
        endcase
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            distance_reg <= res_dist_reg;
            status_reg   <= res_st_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign distance  = distance_reg;
    assign status    = status_reg;

`ifndef NO_ASSERTIONS
    // a write command is acknowledged straight away
    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && (command != CMD_CONVERT) |=> (state_reg == S_DONE) && (res_st_reg == ST_ACK))
        else $error("write transfer not acknowledged");

    // a convert starts the search at the first entry
    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && (command == CMD_CONVERT) |=> (state_reg == S_SEARCH) && (k_reg == '0))
        else $error("convert did not start search at first entry");

    // the search never passes the last used entry
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) |-> (k_reg <= last_reg))
        else $error("search index beyond used entries");

    // a result is loaded only when the output register is free
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> $stable(distance_reg) && $stable(status_reg))
        else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for ir_voltage_to_distance_interp_core. A short table of
// directed transfers loads small voltage and distance tables and probes the
// saturation, interpolation and acknowledge paths. Random traffic follows,
// mostly whole descending table loads and conversions on loaded rows. Every
// result is compared field by field with a typed value or an in-bench model
// of the converter; channels idle at random but for the last of 3 phases.
// ----------------------------------------------------------------------------
module testbench;
    import ivd_pkg::*;

    localparam int SENSORS      = 5;
    localparam int DEPTH        = 64;
    localparam int PHASE_ITEMS  = 475;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 100;

    // command code the block leaves unused
    localparam cmd_t CMD_NOP = 2'd3;

    typedef struct packed {
        cmd_t    cmd;
        sensor_t sensor;
        entry_t  entry;
        level_t  level;
        dist_t   dval;
        used_t   used;
    } item_t;

    typedef struct packed {
        dist_t   distance;
        status_t status;
    } reading_t;

    typedef struct packed {
        item_t    stim;
        logic     typed;
        reading_t want;
    } plan_row_t;

    localparam reading_t ACK = '{8'd0, ST_ACK};

    // directed transfers; typed rows carry the result, the rest are predicted
    localparam int N_DIRECTED = 25;
    localparam plan_row_t DIRECTED [N_DIRECTED] = '{
        '{'{CMD_WR_VOLT, 3'd0, 6'd0, 13'd3000, 8'd0,   7'd0},   1'b1, ACK},
        '{'{CMD_WR_VOLT, 3'd0, 6'd1, 13'd2000, 8'd0,   7'd0},   1'b1, ACK},
        '{'{CMD_WR_VOLT, 3'd0, 6'd2, 13'd1000, 8'd0,   7'd0},   1'b1, ACK},
        '{'{CMD_WR_VOLT, 3'd0, 6'd3, 13'd400,  8'd0,   7'd0},   1'b1, ACK},
        '{'{CMD_WR_DIST, 3'd0, 6'd0, 13'd0,    8'd20,  7'd0},   1'b1, ACK},
        '{'{CMD_WR_DIST, 3'd0, 6'd1, 13'd0,    8'd60,  7'd0},   1'b1, ACK},
        '{'{CMD_WR_DIST, 3'd0, 6'd2, 13'd0,    8'd120, 7'd0},   1'b1, ACK},
        '{'{CMD_WR_DIST, 3'd0, 6'd3, 13'd0,    8'd255, 7'd0},   1'b1, ACK},
        // top of range is nearer than the table, bottom is beyond it
        '{'{CMD_CONVERT, 3'd0, 6'd63, 13'd8191, 8'd0,  7'd4},   1'b1, '{8'd20, ST_NEAR}},
        '{'{CMD_CONVERT, 3'd0, 6'd0,  13'd0,    8'd0,  7'd4},   1'b1, '{8'd255, ST_FAR}},
        // interpolation in the first span, on an entry, and at the far end
        '{'{CMD_CONVERT, 3'd0, 6'd0,  13'd2500, 8'd0,  7'd4},   1'b0, '0},
        '{'{CMD_CONVERT, 3'd0, 6'd0,  13'd2000, 8'd0,  7'd4},   1'b0, '0},
        '{'{CMD_CONVERT, 3'd0, 6'd0,  13'd401,  8'd0,  7'd4},   1'b0, '0},
        // zero used entries behaves as one
        '{'{CMD_CONVERT, 3'd0, 6'd0,  13'd500,  8'd0,  7'd0},   1'b1, '{8'd20, ST_FAR}},
        // used entries above the depth saturate
        '{'{CMD_CONVERT, 3'd0, 6'd0,  13'd500,  8'd0,  7'd127}, 1'b0, '0},
        // sensor index above the count falls back to the last sensor
        '{'{CMD_WR_VOLT, 3'd4, 6'd0, 13'd8191, 8'd0,   7'd0},   1'b1, ACK},
        '{'{CMD_CONVERT, 3'd7, 6'd0, 13'd8191, 8'd0,   7'd1},   1'b1, '{8'd20, ST_NEAR}},
        '{'{CMD_CONVERT, 3'd7, 6'd0, 13'd0,    8'd0,   7'd1},   1'b1, '{8'd20, ST_FAR}},
        // write to a missing sensor and the unused code are acknowledged only
        '{'{CMD_WR_VOLT, 3'd5, 6'd0,  13'd0,    8'd0,   7'd0},   1'b1, ACK},
        '{'{CMD_NOP,     3'd7, 6'd63, 13'd8191, 8'd255, 7'd127}, 1'b1, ACK},
        '{'{CMD_WR_DIST, 3'd0, 6'd63, 13'd0,    8'd0,   7'd0},   1'b1, ACK},
        // table that rises before it falls
        '{'{CMD_WR_VOLT, 3'd1, 6'd0, 13'd1000, 8'd0,   7'd0},   1'b1, ACK},
        '{'{CMD_WR_VOLT, 3'd1, 6'd1, 13'd1500, 8'd0,   7'd0},   1'b1, ACK},
        '{'{CMD_WR_VOLT, 3'd1, 6'd2, 13'd500,  8'd0,   7'd0},   1'b1, ACK},
        '{'{CMD_CONVERT, 3'd1, 6'd0, 13'd800,  8'd0,   7'd3},   1'b0, '0}
    };

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    in_valid     = 1'b0;
    logic    in_ready;
    cmd_t    command      = CMD_CONVERT;
    sensor_t sensor       = '0;
    entry_t  entry        = '0;
    level_t  level_mv     = '0;
    dist_t   dist_value   = '0;
    used_t   used_entries = '0;
    logic    out_valid;
    logic    out_ready    = 1'b0;
    dist_t   distance;
    status_t status;

    // model state: per-sensor voltage rows, shared distance row, written marks
    level_t volt_rows [SENSORS][DEPTH];
    dist_t  dist_row  [DEPTH];
    bit     volt_set  [SENSORS][DEPTH];
    bit     dist_set  [DEPTH];

    reading_t pending_readings [$];
    int       mismatches    = 0;
    int       quiet_cycles  = 0;
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;

    // state of a table load in progress
    int      load_left = 0;
    bit      load_dist;
    sensor_t load_sensor;
    int      load_level;
    int      load_step;

    always #2 clk = ~clk;

    ir_voltage_to_distance_interp_core #(
        .SENSOR_COUNT (SENSORS),
        .TABLE_DEPTH  (DEPTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .sensor       (sensor),
        .entry        (entry),
        .level_mv     (level_mv),
        .dist_value   (dist_value),
        .used_entries (used_entries),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .distance     (distance),
        .status       (status)
    );

    // converts a voltage or applies a write, as the converter does
    function automatic reading_t expected_reading(input item_t it);
        reading_t    r;
        int unsigned s;
        int unsigned n;
        int unsigned v;
        int unsigned hi;
        int unsigned lo;
        int unsigned num;
        int unsigned q;
        bit          found;
        r = ACK;
        case (it.cmd)
            CMD_WR_VOLT:
            begin
                if (it.sensor < SENSORS)
                begin
                    volt_rows[it.sensor][it.entry] = it.level;
                    volt_set[it.sensor][it.entry]  = 1'b1;
                end
            end
            CMD_WR_DIST:
            begin
                dist_row[it.entry] = it.dval;
                dist_set[it.entry] = 1'b1;
            end
            CMD_CONVERT:
            begin
                s = (it.sensor < SENSORS) ? 32'(it.sensor) : SENSORS - 1;
                n = (it.used == 0) ? 1 : ((it.used > DEPTH) ? DEPTH : 32'(it.used));
                v = 32'(it.level);
                if (v >= 32'(volt_rows[s][0]))
                begin
                    r = '{dist_row[0], ST_NEAR};
                end
                else
                begin
                    found = 1'b0;
                    for (int k = 1; k < n && !found; k++)
                    begin
                        if (32'(volt_rows[s][k]) < v)
                        begin
                            hi  = 32'(volt_rows[s][k-1]);
                            lo  = 32'(volt_rows[s][k]);
                            num = (hi - v) * 32'(dist_row[k]) + (v - lo) * 32'(dist_row[k-1]);
                            q   = num / (hi - lo);
                            r   = '{(q > 255) ? 8'd255 : q[7:0], ST_INTERP};
                            found = 1'b1;
                        end
                    end
                    if (!found)
                        r = '{dist_row[n-1], ST_FAR};
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // first table entry a conversion would touch before it has been written
    function automatic bit find_unwritten(input item_t it, output bit in_dist,
                                          output int idx);
        int unsigned s;
        int unsigned n;
        s = (it.sensor < SENSORS) ? 32'(it.sensor) : SENSORS - 1;
        n = (it.used == 0) ? 1 : ((it.used > DEPTH) ? DEPTH : 32'(it.used));
        in_dist = 1'b0;
        idx     = 0;
        if (!volt_set[s][0])
            return 1'b1;
        in_dist = 1'b1;
        if (it.level >= volt_rows[s][0])
            return !dist_set[0];
        for (int k = 1; k < n; k++)
        begin
            if (!volt_set[s][k])
            begin
                in_dist = 1'b0;
                idx     = k;
                return 1'b1;
            end
            if (volt_rows[s][k] < it.level)
            begin
                idx = dist_set[k-1] ? k : k - 1;
                return !(dist_set[k-1] && dist_set[k]);
            end
        end
        idx = n - 1;
        return !dist_set[n-1];
    endfunction

    task automatic start_table_load(input bit dist_load);
        load_dist   = dist_load;
        load_sensor = sensor_t'($urandom_range(0, SENSORS - 1));
        load_level  = dist_load ? $urandom_range(0, 60) : $urandom_range(2000, 8191);
        load_step   = dist_load ? 3 : load_level / DEPTH;
        load_left   = DEPTH;
    endtask

    // table loads, conversions on loaded rows, stray writes and unused codes
    task automatic pick_random_item(output item_t it);
        int    pick;
        int    idx;
        bit    in_dist;
        item_t conv;
        it.cmd    = CMD_CONVERT;
        it.sensor = sensor_t'($urandom_range(0, 7));
        it.entry  = entry_t'($urandom_range(0, DEPTH - 1));
        it.level  = level_t'($urandom_range(0, 8191));
        it.dval   = dist_t'($urandom_range(0, 255));
        it.used   = used_t'($urandom_range(0, 127));
        if (load_left == 0 && $urandom_range(0, 199) < 2)
            start_table_load($urandom_range(0, 5) == 0);
        pick = $urandom_range(0, 99);
        if (load_left > 0)
        begin
            it.entry = entry_t'(DEPTH - load_left);
            if (load_dist)
            begin
                it.cmd  = CMD_WR_DIST;
                it.dval = dist_t'(load_level);
                load_level += $urandom_range(0, load_step);
            end
            else
            begin
                it.cmd    = CMD_WR_VOLT;
                it.sensor = load_sensor;
                it.level  = level_t'(load_level);
                load_level -= $urandom_range(0, load_step);
            end
            load_left--;
        end
        else if (pick < 10)
        begin
            it.cmd = CMD_WR_VOLT;
        end
        else if (pick < 18)
        begin
            it.cmd = CMD_WR_DIST;
        end
        else if (pick < 22)
        begin
            it.cmd = CMD_NOP;
        end
        else
        begin
            conv = it;
            idx  = (conv.sensor < SENSORS) ? conv.sensor : SENSORS - 1;
            if (volt_set[idx][0] && $urandom_range(0, 4) < 3)
                conv.level = level_t'($urandom_range(0, volt_rows[idx][0]));
            pick = $urandom_range(0, 99);
            if (pick < 10)
                conv.used = '0;
            else if (pick < 40)
                conv.used = used_t'(DEPTH);
            else if (pick < 80)
                conv.used = used_t'($urandom_range(1, DEPTH));
            it = conv;
            // fill the entry the search would reach first, instead of converting
            if (find_unwritten(conv, in_dist, idx))
            begin
                it.entry = entry_t'(idx);
                if (in_dist)
                begin
                    it.cmd = CMD_WR_DIST;
                end
                else
                begin
                    it.cmd    = CMD_WR_VOLT;
                    it.sensor = (conv.sensor < SENSORS) ? conv.sensor
                                                        : sensor_t'(SENSORS - 1);
                    if (idx > 0)
                        it.level = level_t'($urandom_range(0, volt_rows[it.sensor][idx-1]));
                end
            end
        end
    endtask

    // one input transfer, then its expected reading is queued
    task automatic send_item(input item_t it, input bit typed, input reading_t want);
        reading_t r;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        command      <= it.cmd;
        sensor       <= it.sensor;
        entry        <= it.entry;
        level_mv     <= it.level;
        dist_value   <= it.dval;
        used_entries <= it.used;
        do
            @(posedge clk);
        while (!in_ready);
        r = expected_reading(it);
        pending_readings.push_back(typed ? want : r);
    endtask

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_reading(input dist_t got_dist, input status_t got_status);
        reading_t exp_r;
        if (pending_readings.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result distance=%0d status=%0d",
                                      got_dist, got_status));
        end
        else
        begin
            exp_r = pending_readings.pop_front();
            if (got_dist !== exp_r.distance)
                report_mismatch($sformatf("distance %0d, wanted %0d",
                                          got_dist, exp_r.distance));
            if (got_status !== exp_r.status)
                report_mismatch($sformatf("status %0d, wanted %0d",
                                          got_status, exp_r.status));
        end
    endtask

    // receiver back-pressure, result checking and idle count
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready)))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (rst_n && out_valid && out_ready)
            check_reading(distance, status);
    end

    // watchdog on cycles with no transfer on either channel
    initial
    begin
        @(posedge rst_n);
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("ERROR: no transfer for %0d cycles", QUIET_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // reset, directed table, random phases, drain
    initial
    begin
        item_t it;
        int    done;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 20;
        recv_idle_pct = 50;
        for (int i = 0; i < N_DIRECTED; i++)
            send_item(DIRECTED[i].stim, DIRECTED[i].typed, DIRECTED[i].want);

        start_table_load(1'b1);
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 20 : ((ph == 1) ? 50 : 0);
            recv_idle_pct = (ph == 0) ? 50 : ((ph == 1) ? 20 : 0);
            done = 0;
            while (done < PHASE_ITEMS)
            begin
                pick_random_item(it);
                send_item(it, 1'b0, '0);
                // writes to a missing sensor and the unused code change nothing
                if (!(it.cmd == CMD_NOP || (it.cmd == CMD_WR_VOLT && it.sensor >= SENSORS)))
                    done++;
            end
        end
        in_valid <= 1'b0;

        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
